// ===== design/pae_pkg.sv =====
// ----------------------------------------------------------------------------
// pae_pkg
// Shared widths, constants and control types for the polygon area,
// bounding box and longest edge block.
// ----------------------------------------------------------------------------
package pae_pkg;

    localparam int COORD_W  = 16;
    localparam int PROD_W   = 2 * COORD_W;
    localparam int CROSS_W  = 48;
    localparam int SUM_W    = CROSS_W + 2;
    localparam int MAG_W    = CROSS_W - 1;
    localparam int LEN_W    = PROD_W + 1;
    localparam int AREA_W   = 40;
    localparam int BOX_W    = 32;
    localparam int DENS_W   = 7;
    localparam int QUO_W    = 7;
    localparam int NUM_W    = MAG_W + 7;
    localparam int DSH_W    = BOX_W + 7;
    localparam int S_DATA_W = 2 * COORD_W;
    localparam int M_DATA_W = 144;
    localparam int CNT_W    = 3;

    localparam logic signed [SUM_W-1:0] CROSS_POS = SUM_W'(48'sh7FFF_FFFF_FFFF);
    localparam logic signed [SUM_W-1:0] CROSS_NEG = -CROSS_POS;
    localparam logic [AREA_W-1:0] AREA_MAX = '1;
    localparam logic [DENS_W-1:0] DENS_MAX = 7'd100;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic cap_in;
        logic cap_close;
        logic acc_vertex;
        logic acc_close;
        logic box;
        logic scale;
        logic div_init;
        logic div_step;
        logic load_out;
    } pae_cmd_t;

    typedef struct packed {
        logic fin;
    } pae_status_t;

endpackage

// ===== design/pae_ctrl.sv =====
// ----------------------------------------------------------------------------
// pae_ctrl
// Sequencer: vertex capture and accumulate, closing edge, box product,
// density division steps and result hand-off.
// ----------------------------------------------------------------------------
module pae_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  pae_pkg::pae_status_t status,
    output pae_pkg::pae_cmd_t    cmd
);
    import pae_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_ACC   = 4'd1;
    localparam logic [3:0] ST_CMUL  = 4'd2;
    localparam logic [3:0] ST_CACC  = 4'd3;
    localparam logic [3:0] ST_BOX   = 4'd4;
    localparam logic [3:0] ST_SCALE = 4'd5;
    localparam logic [3:0] ST_CHECK = 4'd6;
    localparam logic [3:0] ST_DIV   = 4'd7;
    localparam logic [3:0] ST_OUT   = 4'd8;

    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(QUO_W - 1);

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             m_tvalid_reg, m_tvalid_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.cap_in = 1'b1;
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                cmd.acc_vertex = 1'b1;
                state_next     = status.fin ? ST_CMUL : ST_IDLE;
            end
            ST_CMUL: begin
                cmd.cap_close = 1'b1;
                state_next    = ST_CACC;
            end
            ST_CACC: begin
                cmd.acc_close = 1'b1;
                state_next    = ST_BOX;
            end
            ST_BOX: begin
                cmd.box    = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

// ===== design/pae_datapath.sv =====
// ----------------------------------------------------------------------------
// pae_datapath
// Cross products and edge squares, saturating shoelace accumulator,
// bounding box, longest edge, box product, restoring density division
// and the result register.
// ----------------------------------------------------------------------------
module pae_datapath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  pae_pkg::pae_cmd_t              cmd,
    output pae_pkg::pae_status_t           status,
    input  logic [pae_pkg::S_DATA_W-1:0]   in_data,
    input  logic                           in_last,
    output logic [pae_pkg::M_DATA_W-1:0]   out_data,
    output logic                           out_empty
);
    import pae_pkg::*;

    // accumulator state
    logic                     have_first_reg, have_first_next;
    coord_t                   first_x_reg, first_x_next, first_y_reg, first_y_next;
    coord_t                   prev_x_reg, prev_x_next, prev_y_reg, prev_y_next;
    logic signed [CROSS_W-1:0] cross_reg, cross_next;
    coord_t                   min_x_reg, min_x_next, max_x_reg, max_x_next;
    coord_t                   min_y_reg, min_y_next, max_y_reg, max_y_next;
    logic [LEN_W-1:0]         best_len_reg, best_len_next;
    coord_t                   bsx_reg, bsx_next, bsy_reg, bsy_next;
    coord_t                   bex_reg, bex_next, bey_reg, bey_next;

    // product stage
    logic                     fin_reg;
    coord_t                   bx_reg, by_reg;
    logic signed [PROD_W-1:0] pa_reg, pb_reg;
    logic [PROD_W-1:0]        sqx_reg, sqy_reg;

    // result stages
    logic [BOX_W-1:0]         box_reg;
    logic [MAG_W-1:0]         mag_reg;
    logic [NUM_W-1:0]         num_reg, rem_reg;
    logic [DSH_W-1:0]         dsh_reg;
    logic [QUO_W-1:0]         quo_reg;
    logic                     over_reg;
    logic [M_DATA_W-1:0]      out_data_reg;
    logic                     out_empty_reg;

    coord_t                   in_x, in_y, bx_sel, by_sel;
    logic signed [COORD_W:0]  dx, dy;
    logic signed [PROD_W-1:0] pa_full, pb_full;
    logic signed [PROD_W+1:0] sqx_full, sqy_full;
    logic signed [SUM_W-1:0]  sum_raw, sum_sat;
    logic [LEN_W-1:0]         len;
    logic                     longer;
    logic signed [COORD_W:0]  w_full, h_full;
    logic [CROSS_W-1:0]       cross_abs;
    logic [AREA_W-1:0]        area;
    logic [DENS_W-1:0]        dens;
    logic                     box_zero;
    logic                     rem_ge;

    assign status.fin = fin_reg;
    assign out_data   = out_data_reg;
    assign out_empty  = out_empty_reg;

    // products: start at prev, end at the incoming vertex or back at the first
    assign in_x   = coord_t'(in_data[COORD_W-1:0]);
    assign in_y   = coord_t'(in_data[S_DATA_W-1:COORD_W]);
    assign bx_sel = cmd.cap_close ? first_x_reg : in_x;
    assign by_sel = cmd.cap_close ? first_y_reg : in_y;
    assign dx     = (COORD_W+1)'(bx_sel) - (COORD_W+1)'(prev_x_reg);
    assign dy     = (COORD_W+1)'(by_sel) - (COORD_W+1)'(prev_y_reg);
    assign pa_full  = prev_x_reg * by_sel;
    assign pb_full  = prev_y_reg * bx_sel;
    assign sqx_full = dx * dx;
    assign sqy_full = dy * dy;

    always_ff @(posedge aclk) begin
        if (cmd.cap_in) begin
            fin_reg <= in_last;
        end
        if (cmd.cap_in || cmd.cap_close) begin
            bx_reg  <= bx_sel;
            by_reg  <= by_sel;
            pa_reg  <= pa_full;
            pb_reg  <= pb_full;
            sqx_reg <= sqx_full[PROD_W-1:0];
            sqy_reg <= sqy_full[PROD_W-1:0];
        end
    end

    // saturating shoelace add and edge length compare
    always_comb begin
        sum_raw = SUM_W'(cross_reg) + SUM_W'(pa_reg) - SUM_W'(pb_reg);
        if (sum_raw > CROSS_POS) begin
            sum_sat = CROSS_POS;
        end else if (sum_raw < CROSS_NEG) begin
            sum_sat = CROSS_NEG;
        end else begin
            sum_sat = sum_raw;
        end
    end

    assign len    = LEN_W'(sqx_reg) + LEN_W'(sqy_reg);
    assign longer = (len > best_len_reg);

    always_comb begin
        have_first_next = have_first_reg;
        first_x_next    = first_x_reg;
        first_y_next    = first_y_reg;
        prev_x_next     = prev_x_reg;
        prev_y_next     = prev_y_reg;
        cross_next      = cross_reg;
        min_x_next      = min_x_reg;
        max_x_next      = max_x_reg;
        min_y_next      = min_y_reg;
        max_y_next      = max_y_reg;
        best_len_next   = best_len_reg;
        bsx_next        = bsx_reg;
        bsy_next        = bsy_reg;
        bex_next        = bex_reg;
        bey_next        = bey_reg;
        if (cmd.load_out) begin
            have_first_next = 1'b0;
            first_x_next    = '0;
            first_y_next    = '0;
            prev_x_next     = '0;
            prev_y_next     = '0;
            cross_next      = '0;
            min_x_next      = '0;
            max_x_next      = '0;
            min_y_next      = '0;
            max_y_next      = '0;
            best_len_next   = '0;
            bsx_next        = '0;
            bsy_next        = '0;
            bex_next        = '0;
            bey_next        = '0;
        end else if (cmd.acc_vertex && !have_first_reg) begin
            have_first_next = 1'b1;
            first_x_next    = bx_reg;
            first_y_next    = by_reg;
            min_x_next      = bx_reg;
            max_x_next      = bx_reg;
            min_y_next      = by_reg;
            max_y_next      = by_reg;
            prev_x_next     = bx_reg;
            prev_y_next     = by_reg;
        end else if (cmd.acc_vertex || cmd.acc_close) begin
            cross_next = sum_sat[CROSS_W-1:0];
            if (longer) begin
                best_len_next = len;
                bsx_next      = prev_x_reg;
                bsy_next      = prev_y_reg;
                bex_next      = bx_reg;
                bey_next      = by_reg;
            end
            if (cmd.acc_vertex) begin
                prev_x_next = bx_reg;
                prev_y_next = by_reg;
                if (bx_reg < min_x_reg) begin
                    min_x_next = bx_reg;
                end
                if (bx_reg > max_x_reg) begin
                    max_x_next = bx_reg;
                end
                if (by_reg < min_y_reg) begin
                    min_y_next = by_reg;
                end
                if (by_reg > max_y_reg) begin
                    max_y_next = by_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_first_reg <= 1'b0;
            first_x_reg    <= '0;
            first_y_reg    <= '0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            cross_reg      <= '0;
            min_x_reg      <= '0;
            max_x_reg      <= '0;
            min_y_reg      <= '0;
            max_y_reg      <= '0;
            best_len_reg   <= '0;
            bsx_reg        <= '0;
            bsy_reg        <= '0;
            bex_reg        <= '0;
            bey_reg        <= '0;
        end else begin
            have_first_reg <= have_first_next;
            first_x_reg    <= first_x_next;
            first_y_reg    <= first_y_next;
            prev_x_reg     <= prev_x_next;
            prev_y_reg     <= prev_y_next;
            cross_reg      <= cross_next;
            min_x_reg      <= min_x_next;
            max_x_reg      <= max_x_next;
            min_y_reg      <= min_y_next;
            max_y_reg      <= max_y_next;
            best_len_reg   <= best_len_next;
            bsx_reg        <= bsx_next;
            bsy_reg        <= bsy_next;
            bex_reg        <= bex_next;
            bey_reg        <= bey_next;
        end
    end

    // box product, magnitude, scale by 100 and density division
    assign w_full    = (COORD_W+1)'(max_x_reg) - (COORD_W+1)'(min_x_reg);
    assign h_full    = (COORD_W+1)'(max_y_reg) - (COORD_W+1)'(min_y_reg);
    assign cross_abs = cross_reg[CROSS_W-1] ? CROSS_W'(-cross_reg) : CROSS_W'(cross_reg);
    assign rem_ge    = (rem_reg >= NUM_W'(dsh_reg));

    always_ff @(posedge aclk) begin
        if (cmd.box) begin
            box_reg <= w_full[COORD_W-1:0] * h_full[COORD_W-1:0];
            mag_reg <= cross_abs[MAG_W-1:0];
        end
        if (cmd.scale) begin
            num_reg <= (NUM_W'(mag_reg) << 6) + (NUM_W'(mag_reg) << 5)
                       + (NUM_W'(mag_reg) << 2);
        end
        if (cmd.div_init) begin
            over_reg <= (num_reg >= (NUM_W'(box_reg) << 8));
            rem_reg  <= num_reg;
            dsh_reg  <= DSH_W'(box_reg) << 7;
            quo_reg  <= '0;
        end else if (cmd.div_step) begin
            if (rem_ge) begin
                rem_reg <= rem_reg - NUM_W'(dsh_reg);
            end
            quo_reg <= {quo_reg[QUO_W-2:0], rem_ge};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    assign box_zero = (box_reg == '0);
    assign area     = (mag_reg > MAG_W'(AREA_MAX)) ? AREA_MAX : mag_reg[AREA_W-1:0];

    always_comb begin
        if (box_zero) begin
            dens = '0;
        end else if (over_reg || quo_reg > DENS_MAX) begin
            dens = DENS_MAX;
        end else begin
            dens = quo_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_data_reg  <= {1'b0, bey_reg, bex_reg, bsy_reg, bsx_reg, dens, box_reg, area};
            out_empty_reg <= box_zero;
        end
    end

endmodule

// ===== design/polygon_area_bbox_edge_metrics.sv =====
// ----------------------------------------------------------------------------
// polygon_area_bbox_edge_metrics
// Shoelace area, bounding box, fill density and longest edge of a polygon
// streamed in one vertex per transfer.
//
//   channel   dir   ports                     content
//   s_        in    tvalid tready tdata tlast  vertex x/y, tlast on last vertex
//   m_        out   tvalid tready tdata tuser  area, box, density, edge; box empty
//
// a vertex: capture with the cross and edge multipliers,
// then the saturating accumulate
// the last vertex adds the closing edge (capture, accumulate), box product,
// scale by 100, division setup, a 7-step restoring divider and the result load
// the result register frees s_tready while a result waits on m_tready;
// only the final load waits for it
// aresetn clears the accumulated polygon and drops m_tvalid
// ----------------------------------------------------------------------------
module polygon_area_bbox_edge_metrics (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [pae_pkg::S_DATA_W-1:0]   s_tdata,   // vertex_x, vertex_y
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // area_doubled, box_area, density_percent, edge_start_x, edge_start_y,
    // edge_end_x, edge_end_y, zero pad
    output logic [pae_pkg::M_DATA_W-1:0]   m_tdata,
    output logic                           m_tuser    // box_empty
);
    import pae_pkg::*;

    pae_cmd_t    cmd;
    pae_status_t status;

    pae_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pae_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .in_data   (s_tdata),
        .in_last   (s_tlast),
        .out_data  (m_tdata),
        .out_empty (m_tuser)
    );

endmodule

// ===== design/pae_checker.sv =====
// ----------------------------------------------------------------------------
// pae_checker
// Port-level checks on the polygon metrics block, bound to the top level.
// ----------------------------------------------------------------------------
module pae_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic [pae_pkg::S_DATA_W-1:0] s_tdata,
    input logic                         s_tlast,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [pae_pkg::M_DATA_W-1:0] m_tdata,
    input logic                         m_tuser
);
    import pae_pkg::*;

    logic [DENS_W-1:0] dens;
    assign dens = m_tdata[AREA_W+BOX_W+DENS_W-1:AREA_W+BOX_W];

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_one_vertex: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("vertex transfer in back-to-back cycles");

    a_dens_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> dens <= DENS_MAX)
        else $error("density above 100");

    a_empty_dens: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> dens == '0)
        else $error("empty box with nonzero density");

endmodule

bind polygon_area_bbox_edge_metrics pae_checker u_pae_checker (.*);
